[hw/rtl/sbus_pkg.sv]
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared types and constants for the sbus frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbus_pkg;

  localparam int unsigned CHAN_BITS = 11;
  localparam int unsigned NUM_CHAN  = 16;
  localparam int unsigned CHAN_IDX_W = $clog2(NUM_CHAN);
  localparam int unsigned BIT_CNT_W  = $clog2(CHAN_BITS);
  localparam int unsigned POS_W      = 5;

  localparam logic [POS_W-1:0] POS_HUNT       = 5'd0;
  localparam logic [POS_W-1:0] POS_FIRST_DATA = 5'd1;
  localparam logic [POS_W-1:0] POS_LAST_DATA  = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAG       = 5'd23;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(CHAN_BITS - 1);
  localparam logic [CHAN_IDX_W-1:0] CHAN_LAST = CHAN_IDX_W'(NUM_CHAN - 1);

  localparam logic [1:0] CFG_HEADER     = 2'd0;
  localparam logic [1:0] CFG_FOOTER     = 2'd1;
  localparam logic [1:0] CFG_ALT_FOOTER = 2'd2;

  localparam logic [7:0] HEADER_RESET     = 8'h0F;
  localparam logic [7:0] FOOTER_RESET     = 8'h00;
  localparam logic [3:0] ALT_FOOTER_RESET = 4'h4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/sbus_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top
// Frame decoder: hunts for the header, unpacks 22 data bytes bit-serially
// into sixteen 11-bit channels, checks the footer and streams the channels.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid/in_stall   | rx_byte
//  out      | output    | out_valid/out_stall | channel_index, channel_value, flags
//  cfg      | input     | cfg_write           | cfg_index, cfg_data
//
//  a data byte is transferred in idle, then shifted bit by bit through the bit shifter
//  any other byte is taken in idle alone; a good footer starts the emit of all 16 channels, held by out_stall
//  results go out one per cycle while out_stall is low
//  in_stall is high while the shifter or the emit sequencer is busy
//  rst is synchronous; configuration returns to header 0x0F, footer 0x00, alt 0x4
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       channel_index,
  output logic [10:0]      channel_value,
  output logic             digital_one,
  output logic             digital_two,
  output logic             frame_lost,
  output logic             fail_safe,
  output logic             last_channel,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  sbus_pkg::state_t state, state_next;

  logic [7:0] header_reg;
  logic [7:0] footer_reg;
  logic [3:0] alt_footer_reg;

  logic [sbus_pkg::POS_W-1:0]      byte_position, byte_position_next;
  logic [7:0]                      byte_sr, byte_sr_next;
  logic [2:0]                      shift_cnt, shift_cnt_next;
  logic [sbus_pkg::CHAN_BITS-1:0]  chan_sr, chan_sr_next;
  logic [sbus_pkg::BIT_CNT_W-1:0]  bit_cnt, bit_cnt_next;
  logic [sbus_pkg::CHAN_IDX_W-1:0] chan_cnt, chan_cnt_next;
  logic [sbus_pkg::CHAN_IDX_W-1:0] emit_idx, emit_idx_next;
  logic [3:0]                      flag_reg, flag_reg_next;
  logic                            out_valid_next;

  logic [sbus_pkg::CHAN_BITS-1:0] chan_mem [sbus_pkg::NUM_CHAN];

  logic in_xfer;
  logic out_xfer;
  logic load;
  logic mem_we;
  logic footer_ok;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign footer_ok = (rx_byte == footer_reg) || (rx_byte[3:0] == alt_footer_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg     <= sbus_pkg::HEADER_RESET;
      footer_reg     <= sbus_pkg::FOOTER_RESET;
      alt_footer_reg <= sbus_pkg::ALT_FOOTER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sbus_pkg::CFG_HEADER:     header_reg     <= cfg_data;
        sbus_pkg::CFG_FOOTER:     footer_reg     <= cfg_data;
        sbus_pkg::CFG_ALT_FOOTER: alt_footer_reg <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next         = state;
    byte_position_next = byte_position;
    byte_sr_next       = byte_sr;
    shift_cnt_next     = shift_cnt;
    chan_sr_next       = chan_sr;
    bit_cnt_next       = bit_cnt;
    chan_cnt_next      = chan_cnt;
    emit_idx_next      = emit_idx;
    flag_reg_next      = flag_reg;
    out_valid_next     = out_valid && !out_xfer;
    in_stall           = 1'b1;
    load               = 1'b0;
    mem_we             = 1'b0;

    case (state)
      sbus_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_xfer) begin
          if (byte_position == sbus_pkg::POS_HUNT) begin
            if (rx_byte == header_reg) begin
              byte_position_next = sbus_pkg::POS_FIRST_DATA;
              bit_cnt_next       = '0;
              chan_cnt_next      = '0;
            end
          end else if (byte_position <= sbus_pkg::POS_LAST_DATA) begin
            byte_sr_next       = rx_byte;
            shift_cnt_next     = '0;
            byte_position_next = byte_position + 5'd1;
            state_next         = sbus_pkg::ST_SHIFT;
          end else if (byte_position == sbus_pkg::POS_FLAG) begin
            flag_reg_next      = rx_byte[3:0];
            byte_position_next = byte_position + 5'd1;
          end else begin
            byte_position_next = sbus_pkg::POS_HUNT;
            if (footer_ok) begin
              emit_idx_next = '0;
              state_next    = sbus_pkg::ST_EMIT;
            end
          end
        end
      end

      sbus_pkg::ST_SHIFT: begin
        // lsb-first bit into the channel shifter
        chan_sr_next   = {byte_sr[0], chan_sr[sbus_pkg::CHAN_BITS-1:1]};
        byte_sr_next   = {1'b0, byte_sr[7:1]};
        shift_cnt_next = shift_cnt + 3'd1;
        if (bit_cnt == sbus_pkg::BIT_LAST) begin
          mem_we        = 1'b1;
          bit_cnt_next  = '0;
          chan_cnt_next = chan_cnt + 4'd1;
        end else begin
          bit_cnt_next = bit_cnt + 4'd1;
        end
        if (shift_cnt == 3'd7) begin
          state_next = sbus_pkg::ST_IDLE;
        end
      end

      sbus_pkg::ST_EMIT: begin
        load = !out_valid || !out_stall;
        if (load) begin
          out_valid_next = 1'b1;
          emit_idx_next  = emit_idx + 4'd1;
          if (emit_idx == sbus_pkg::CHAN_LAST) begin
            state_next = sbus_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = sbus_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sbus_pkg::ST_IDLE;
      byte_position <= sbus_pkg::POS_HUNT;
      shift_cnt     <= '0;
      bit_cnt       <= '0;
      chan_cnt      <= '0;
      emit_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      byte_position <= byte_position_next;
      shift_cnt     <= shift_cnt_next;
      bit_cnt       <= bit_cnt_next;
      chan_cnt      <= chan_cnt_next;
      emit_idx      <= emit_idx_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_sr  <= byte_sr_next;
    chan_sr  <= chan_sr_next;
    flag_reg <= flag_reg_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      chan_mem[chan_cnt] <= chan_sr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel_value <= chan_mem[emit_idx];
      channel_index <= emit_idx;
      last_channel  <= (emit_idx == sbus_pkg::CHAN_LAST);
      digital_one   <= flag_reg[0];
      digital_two   <= flag_reg[1];
      frame_lost    <= flag_reg[2];
      fail_safe     <= flag_reg[3];
    end
  end

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sbus_pkg::ST_EMIT)
    else $error("result appeared outside emit");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_channel |-> channel_index == sbus_pkg::CHAN_LAST)
    else $error("last flag on wrong channel");

  a_frame_complete: assert property (@(posedge clk) disable iff (rst)
    state == sbus_pkg::ST_EMIT |-> chan_cnt == '0 && bit_cnt == '0)
    else $error("emit with partial frame");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !last_channel |=>
      out_valid && channel_index == $past(channel_index) + 4'd1)
    else $error("channel sequence broken");

endmodule

`default_nettype wire
